/* sv/iptp_pkg.sv */
package iptp_pkg;

    localparam logic [7:0] CHAR_PERIOD = 8'h2e;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [2:0]  PORT_INDEX    = 3'd4;
    localparam logic [2:0]  LAST_DOT_IDX  = 3'd2;
    localparam logic [15:0] SAT_MAX       = 16'hffff;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_SKIP   = 3'b010,
        PH_NUMBER = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] char_in;
        logic       run_start;
        logic       buffer_last;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [7:0]  octet_first;
        logic [7:0]  octet_second;
        logic [7:0]  octet_third;
        logic [7:0]  octet_fourth;
        logic [15:0] port_number;
    } t_out_req;

endpackage

/* sv/iptp_in_if.sv */
interface iptp_in_if;
    logic              valid;
    logic              ready;
    iptp_pkg::t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/iptp_out_if.sv */
interface iptp_out_if;
    logic               valid;
    logic               ready;
    iptp_pkg::t_out_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/ipv4_port_text_parser_core.sv */
// a result request is registered in the output register, or in the skid entry while the output register is held
// throughput: one byte per cycle while the skid entry is empty; parse state updates in the cycle a byte is accepted
// an output register plus one skid entry keep input flowing while a result waits
// input stalls only while the skid entry is occupied
// reset (synchronous, active low): parser idle, output and skid empty
module ipv4_port_text_parser_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iptp_in_if.sink   i_in,
    iptp_out_if.source o_out
);

    iptp_pkg::t_phase   r_phase, n_phase;
    logic [2:0]         r_idx, n_idx;
    logic [15:0]        r_acc, n_acc;
    logic               r_seen, n_seen;
    logic [7:0]         r_oct [0:3];
    logic               oct_we;

    logic               res_valid;
    logic [1:0]         res_status;
    iptp_pkg::t_out_req res;

    iptp_pkg::t_out_req r_out, r_skid;
    logic               r_out_valid, r_skid_valid;

    logic               in_fire, out_fire;
    logic               is_digit;
    logic [19:0]        mac;
    logic [7:0]         c;

    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = r_out_valid && o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign c        = i_in.data.char_in;
    assign is_digit = (c >= iptp_pkg::CHAR_ZERO) && (c <= iptp_pkg::CHAR_NINE);
    assign mac      = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {16'd0, 4'(c - iptp_pkg::CHAR_ZERO)};

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_acc      = r_acc;
        n_seen     = r_seen;
        oct_we     = 1'b0;
        res_valid  = 1'b0;
        res_status = iptp_pkg::STATUS_OK;
        if (i_in.data.run_start) begin
            n_phase = iptp_pkg::PH_SKIP;
            n_idx   = '0;
            n_acc   = '0;
            n_seen  = 1'b0;
            if (i_in.data.buffer_last) begin
                res_valid  = 1'b1;
                res_status = iptp_pkg::STATUS_SHORT;
            end
        end else begin
            unique case (r_phase)
                iptp_pkg::PH_IDLE: begin
                end
                iptp_pkg::PH_SKIP: begin
                    n_phase = iptp_pkg::PH_NUMBER;
                    n_idx   = '0;
                    n_acc   = '0;
                    n_seen  = 1'b0;
                    if (i_in.data.buffer_last) begin
                        res_valid  = 1'b1;
                        res_status = iptp_pkg::STATUS_SHORT;
                    end
                end
                iptp_pkg::PH_NUMBER: begin
                    if (is_digit) begin
                        n_acc  = (mac > {4'd0, iptp_pkg::SAT_MAX}) ? iptp_pkg::SAT_MAX
                                                                   : mac[15:0];
                        n_seen = 1'b1;
                        if (i_in.data.buffer_last) begin
                            res_valid  = 1'b1;
                            res_status = iptp_pkg::STATUS_SHORT;
                        end
                    end else if (!r_seen) begin
                        res_valid  = 1'b1;
                        res_status = iptp_pkg::STATUS_BAD;
                    end else if (r_idx < iptp_pkg::PORT_INDEX) begin
                        if (c != ((r_idx <= iptp_pkg::LAST_DOT_IDX) ? iptp_pkg::CHAR_PERIOD
                                                                   : iptp_pkg::CHAR_COLON))
                        begin
                            res_valid  = 1'b1;
                            res_status = iptp_pkg::STATUS_BAD;
                        end else begin
                            oct_we = 1'b1;
                            n_idx  = r_idx + 3'd1;
                            n_acc  = '0;
                            n_seen = 1'b0;
                            if (i_in.data.buffer_last) begin
                                res_valid  = 1'b1;
                                res_status = iptp_pkg::STATUS_SHORT;
                            end
                        end
                    end else begin
                        res_valid  = 1'b1;
                        res_status = iptp_pkg::STATUS_OK;
                    end
                end
                default: begin
                    n_phase = iptp_pkg::PH_IDLE;
                end
            endcase
            if (res_valid) begin
                n_phase = iptp_pkg::PH_IDLE;
            end
        end
        if (i_in.data.run_start && i_in.data.buffer_last) begin
            n_phase = iptp_pkg::PH_IDLE;
        end
    end

    always_comb begin
        res = '0;
        res.parse_status = res_status;
        if (res_status == iptp_pkg::STATUS_OK) begin
            res.octet_first  = r_oct[0];
            res.octet_second = r_oct[1];
            res.octet_third  = r_oct[2];
            res.octet_fourth = r_oct[3];
            res.port_number  = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= iptp_pkg::PH_IDLE;
            r_idx   <= '0;
            r_acc   <= '0;
            r_seen  <= 1'b0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
        end
    end

    // completed octets
    always_ff @(posedge i_clk) begin
        if (in_fire && oct_we) begin
            r_oct[r_idx[1:0]] <= r_acc[7:0];
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
